// ----- rtl/core/line_position_estimator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Line position estimator assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_ESTIMATOR_UNIT_ASSERT_SVH
`define LINE_POSITION_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, quiet during reset
`define LPE_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lpe check failed");

// next-cycle implication
`define LPE_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lpe check failed");

`endif

// ----- rtl/core/lpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Line position estimator package
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lpe_pkg;

	localparam int SENSORS       = 8;
	localparam int FULL_SCALE    = 2500;
	localparam int POSITION_UNIT = 1000;

	localparam int RAW_W  = 12;
	localparam int CFG_W  = 13;
	localparam int ERR_W  = 14;
	localparam int IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	// shared divider: dividend holds the weighted position sum, divisor the
	// weight total, quotient the larger of full scale and the last position
	localparam int DVD_W  = 28;
	localparam int DEN_W  = 15;
	localparam int QUO_W  = 13;
	localparam int CNT_W  = $clog2(QUO_W + 1);

	localparam logic [RAW_W-1:0] FS_VAL = RAW_W'(FULL_SCALE);

	typedef enum logic [1:0] {
		REQ_CAL   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_IN_LINE = 2'd0,
		CFG_NOISE   = 2'd1,
		CFG_CENTER  = 2'd2,
		CFG_SPARE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CAL,
		S_CLR,
		S_MAP_PREP,
		S_MAP_GO,
		S_MAP_DIV,
		S_MAP_ACC,
		S_AVG_GO,
		S_AVG_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic do_cal;
		logic do_clr;
		logic map_prep;
		logic map_take;
		logic map_acc;
		logic div_start;
		logic sel_avg;
		logic avg_take;
		logic finish;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic need_div;
		logic idx_last;
		logic need_avg;
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic logic [QUO_W-1:0] pos_weight(input logic [IDX_W-1:0] idx);
		pos_weight = QUO_W'(idx) * QUO_W'(POSITION_UNIT);
	endfunction

endpackage

// ----- rtl/core/line_position_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// Line position estimator
// Calibrated mapping of eight reflectance sensors and line error estimate.
// ----------------------------------------------------------------------------
// channel  | direction | beat contents
// s_axis   | in        | tuser: req_type; tdata: raw_0..raw_7
// m_axis   | out       | tdata: mapped_0..mapped_7, line_error, in_line
// cfg      | in        | cfg_index, cfg_data (register write)
//
// Calibrate returns to ready via the dispatch state, clear also via S_CLR; a
// read maps each sensor, via the shared divider when the raw value is inside
// a non-flat window, then divides for the weighted mean. Reset is asynchronous
// and restores the empty calibration windows at once. A stalled result waits
// in the output register; the next item is taken meanwhile and finishes when it frees.
// ----------------------------------------------------------------------------
`include "line_position_estimator_unit_assert.svh"

module line_position_estimator_unit
	import lpe_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [95:0]   s_axis_tdata,  // raw_0 .. raw_7, 12 bits each
	input  logic [1:0]    s_axis_tuser,  // req_type
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [111:0]  m_axis_tdata,  // mapped_0 .. mapped_7, line_error, in_line, pad
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [12:0]   cfg_data
);

	cmd_t              cmd;
	stat_t             stat;
	logic [DVD_W-1:0]  dvd;
	logic [DEN_W-1:0]  dvs;
	logic [QUO_W-1:0]  quo;
	logic              div_busy, div_done;
	logic [110:0]      out_data;

	assign cfg_ready = 1'b1;

	lpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpe_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	lpe_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_req       (s_axis_tuser),
		.in_raw       (s_axis_tdata),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_idx      (cfg_index),
		.cfg_wdata    (cfg_data),
		.div_dividend (dvd),
		.div_divisor  (dvs),
		.div_quotient (quo),
		.div_done     (div_done),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (out_data)
	);

	assign m_axis_tdata = {1'b0, out_data};

	`LPE_ASSERT_IMP(a_start_idle, cmd.div_start, !div_busy)
	`LPE_ASSERT_NXT(a_start_busy, cmd.div_start, div_busy)
	`LPE_ASSERT_IMP(a_finish_read, cmd.finish, stat.req == REQ_READ)
	`LPE_ASSERT_NXT(a_finish_valid, cmd.finish, m_axis_tvalid)

endmodule

// ----- rtl/core/lpe_divider.sv -----
// ----------------------------------------------------------------------------
// Line position estimator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpe_divider
	import lpe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [QUO_W-1:0] quotient,
	output logic             busy,
	output logic             done
);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient is known to fit QUO_W bits, so the top slice starts below divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DVD_W-1:QUO_W];
			quo_q <= dividend[QUO_W-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

// ----- rtl/core/lpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// Line position estimator controller
// Sequences calibration, per-sensor mapping, averaging and result output.
// ----------------------------------------------------------------------------
module lpe_ctrl
	import lpe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CAL;
				end
			end
			S_CAL: begin
				// dispatch on the registered request
				unique case (stat.req)
					REQ_CAL:   begin cmd.do_cal = 1'b1; state_d = S_IDLE; end
					REQ_READ:  state_d = S_MAP_PREP;
					REQ_CLEAR: state_d = S_CLR;
					default:   state_d = S_IDLE;
				endcase
			end
			S_CLR: begin
				cmd.do_clr = 1'b1;
				state_d    = S_IDLE;
			end
			S_MAP_PREP: begin
				cmd.map_prep = 1'b1;
				state_d      = stat.need_div ? S_MAP_GO : S_MAP_ACC;
			end
			S_MAP_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_MAP_DIV;
			end
			S_MAP_DIV: begin
				if (stat.div_done) begin
					cmd.map_take = 1'b1;
					state_d      = S_MAP_ACC;
				end
			end
			S_MAP_ACC: begin
				cmd.map_acc = 1'b1;
				state_d     = stat.idx_last ? S_AVG_GO : S_MAP_PREP;
			end
			S_AVG_GO: begin
				if (stat.need_avg) begin
					cmd.div_start = 1'b1;
					cmd.sel_avg   = 1'b1;
					state_d       = S_AVG_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_AVG_DIV: begin
				if (stat.div_done) begin
					cmd.avg_take = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/lpe_datapath.sv -----
// ----------------------------------------------------------------------------
// Line position estimator datapath
// Calibration windows, mapping, weighted sums, error and output register.
// ----------------------------------------------------------------------------
module lpe_datapath
	import lpe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [1:0]             in_req,
	input  logic [8*RAW_W-1:0]     in_raw,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata,
	output logic [DVD_W-1:0]       div_dividend,
	output logic [DEN_W-1:0]       div_divisor,
	input  logic [QUO_W-1:0]       div_quotient,
	input  logic                   div_done,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [8*RAW_W+ERR_W:0] out_data
);

	logic [RAW_W-1:0]        in_line_th_q, noise_th_q;
	logic [CFG_W-1:0]        center_q;
	req_t                    req_q;
	logic [RAW_W-1:0]        raw_q   [SENSORS];
	logic [RAW_W-1:0]        min_q   [SENSORS];
	logic [RAW_W-1:0]        max_q   [SENSORS];
	logic [RAW_W-1:0]        map_q   [SENSORS];
	logic [IDX_W-1:0]        idx_q;
	logic [DVD_W-1:0]        num_q, wsum_q;
	logic [DEN_W-1:0]        den_q, tot_q;
	logic [RAW_W-1:0]        mval_q;
	logic                    seen_q;
	logic [QUO_W-1:0]        pos_q;
	logic signed [ERR_W-1:0] prev_err_q, err;
	logic                    out_valid_q;
	logic [8*RAW_W+ERR_W:0]  out_data_q;

	logic [RAW_W-1:0]   raw_sel, lo_sel, hi_sel, diff;
	logic [2*RAW_W-1:0] prod;
	logic               below, above, flat;
	logic [8*RAW_W-1:0] map_flat;

	assign raw_sel = raw_q[idx_q];
	assign lo_sel  = min_q[idx_q];
	assign hi_sel  = max_q[idx_q];
	assign below   = raw_sel < lo_sel;
	assign above   = raw_sel > hi_sel;
	assign flat    = hi_sel == lo_sel;
	assign diff    = raw_sel - lo_sel;
	assign prod    = (2*RAW_W)'(diff) * (2*RAW_W)'(FS_VAL);

	assign div_dividend = cmd.sel_avg ? wsum_q : num_q;
	assign div_divisor  = cmd.sel_avg ? tot_q  : den_q;

	always_comb begin
		stat          = '0;
		stat.req      = req_q;
		stat.need_div = !below && !above && !flat;
		stat.idx_last = idx_q == IDX_W'(SENSORS - 1);
		stat.need_avg = seen_q && (tot_q != '0);
		stat.div_done = div_done;
		stat.out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		if (seen_q) begin
			err = ERR_W'($signed({1'b0, pos_q})) - ERR_W'($signed({1'b0, center_q}));
		end else if (prev_err_q > 0) begin
			err = ERR_W'($signed({1'b0, center_q}));
		end else if (prev_err_q < 0) begin
			err = -ERR_W'($signed({1'b0, center_q}));
		end else begin
			err = '0;
		end
	end

	always_comb begin
		map_flat = '0;
		for (int i = 0; i < SENSORS; i++) map_flat[i*RAW_W +: RAW_W] = map_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_th_q <= '0;
			noise_th_q   <= '0;
			center_q     <= CFG_W'(3500);
			req_q        <= REQ_NONE;
			idx_q        <= '0;
			seen_q       <= 1'b0;
			prev_err_q   <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < SENSORS; i++) begin
				min_q[i] <= FS_VAL;
				max_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_IN_LINE: in_line_th_q <= cfg_wdata[RAW_W-1:0];
					CFG_NOISE:   noise_th_q   <= cfg_wdata[RAW_W-1:0];
					CFG_CENTER:  center_q     <= cfg_wdata;
					default:     ;
				endcase
			end
			if (cmd.load_in) begin
				req_q  <= req_t'(in_req);
				idx_q  <= '0;
				seen_q <= 1'b0;
			end
			if (cmd.do_cal) begin
				for (int i = 0; i < SENSORS; i++) begin
					if (raw_q[i] < min_q[i])      min_q[i] <= raw_q[i];
					else if (raw_q[i] > max_q[i]) max_q[i] <= raw_q[i];
				end
			end
			if (cmd.do_clr) begin
				for (int i = 0; i < SENSORS; i++) begin
					min_q[i] <= FS_VAL;
					max_q[i] <= '0;
				end
				prev_err_q <= '0;
			end
			if (cmd.map_acc) begin
				if (mval_q > in_line_th_q) seen_q <= 1'b1;
				if (!stat.idx_last) idx_q <= idx_q + 1'b1;
			end
			if (cmd.finish) prev_err_q <= err;
			// drop valid on take, raise on a new result
			if (cmd.finish)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			for (int i = 0; i < SENSORS; i++) begin
				raw_q[i] <= in_raw[i*RAW_W +: RAW_W];
				map_q[i] <= '0;
			end
			wsum_q <= '0;
			tot_q  <= '0;
			pos_q  <= '0;
		end
		if (cmd.map_prep) begin
			num_q  <= DVD_W'(prod);
			den_q  <= DEN_W'(hi_sel - lo_sel);
			// below the minimum wins over above the maximum on an empty window
			mval_q <= (above && !below) ? FS_VAL : '0;
		end
		if (cmd.map_take) mval_q <= div_quotient[RAW_W-1:0];
		if (cmd.map_acc) begin
			map_q[idx_q] <= mval_q;
			if (mval_q > noise_th_q) begin
				wsum_q <= wsum_q + DVD_W'(DVD_W'(mval_q) * DVD_W'(pos_weight(idx_q)));
				tot_q  <= tot_q + DEN_W'(mval_q);
			end
		end
		if (cmd.avg_take) pos_q <= div_quotient;
		if (cmd.finish) out_data_q <= {seen_q, err, map_flat};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
